// ----- hw/rtl/sbb_pkg.sv -----
// shared types, constants and state codes for the separable box blur block
package sbb_pkg;

	localparam int NUM_CH   = 3;   // red, green, blue
	localparam int PIX_W    = 8;   // one sample
	localparam int SUM_W    = 13;  // holds 31 samples of 255
	localparam int DIV_W    = 5;   // window length 2r+1, at most 31
	localparam int QBIT_W   = 3;   // quotient bit position, 8 bits of quotient
	localparam int COORD_SW = 9;   // signed window coordinate before clamping
	localparam int SIZE_W   = 8;   // image size registers
	localparam int RAD_W    = 4;   // radius register
	localparam int RAD_CAP  = 15;  // largest radius the register can hold
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 32;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLUR_RADIUS  = 2'd2;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 8'd128;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 8'd128;
	localparam logic [RAD_W-1:0]  RADIUS_RST = 4'd1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// index 2 is red, 1 green, 0 blue, matching the 24-bit store word
	typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;
	typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_ROWDIV,
		ST_COLDIV,
		ST_DONE
	} sbb_state_t;

endpackage

// ----- hw/rtl/sbb_pixel_mem.sv -----
// pixel store: one write port, one read port with registered read data
module sbb_pixel_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/sbb_divider.sv -----
// three-channel restoring divider, one quotient bit per cycle
module sbb_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  sbb_pkg::div_req_t req,
	input  sbb_pkg::sum_vec_t dividend,
	output sbb_pkg::div_sts_t sts,
	output sbb_pkg::pix_t     quotient
);
	import sbb_pkg::*;

	sum_vec_t          rem_q;
	pix_t              quo_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [QBIT_W-1:0] bit_q;
	logic              busy_q;
	logic              done_q;

	sum_vec_t          rem_d;
	pix_t              quo_d;
	logic [SUM_W-1:0]  shifted;

	always_comb begin
		rem_d   = rem_q;
		quo_d   = quo_q;
		shifted = SUM_W'(divisor_q) << bit_q;
		for (int c = 0; c < NUM_CH; c++) begin
			if (rem_q[c] >= shifted) begin
				rem_d[c]        = rem_q[c] - shifted;
				quo_d[c][bit_q] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= QBIT_W'(PIX_W - 1);
		end else if (busy_q) begin
			bit_q <= bit_q - 1'b1;
			if (bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= dividend;
			quo_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && bit_q == '0 && !req.start) |=> done_q)
		else $error("divider did not finish after last bit");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q[0] < SUM_W'(divisor_q)) && (rem_q[1] < SUM_W'(divisor_q))
			&& (rem_q[2] < SUM_W'(divisor_q)))
		else $error("divider remainder not below divisor");

endmodule

// ----- hw/rtl/separable_box_blur_rgb.sv -----
// top level: pixel store with box-blur queries, apb register port
//
//  channel | handshake          | beat payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | kind, col, row, in_red, in_green, in_blue
//  out     | out_valid/out_ready| out_red, out_green, out_blue, coord_error
//  cfg     | psel/penable/pready| paddr, pwdata, pwrite, prdata (3 registers)
//
//  a load beat writes the store at the accept edge
//  a query does one store read per window sample, then a drain step and a divide per
//  window row, plus one divide for the column
//  an out-of-range query goes straight to ST_DONE; no clearing pass after reset
//  in_ready drops while a query is at work; a waiting result holds only ST_DONE
module separable_box_blur_rgb #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_RADIUS = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input beats
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [6:0]                col,
	input  logic [6:0]                row,
	input  logic [sbb_pkg::PIX_W-1:0] in_red,
	input  logic [sbb_pkg::PIX_W-1:0] in_green,
	input  logic [sbb_pkg::PIX_W-1:0] in_blue,
	// result beats
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sbb_pkg::PIX_W-1:0] out_red,
	output logic [sbb_pkg::PIX_W-1:0] out_green,
	output logic [sbb_pkg::PIX_W-1:0] out_blue,
	output logic                      coord_error,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sbb_pkg::CFG_AW-1:0] paddr,
	input  logic [sbb_pkg::CFG_DW-1:0] pwdata,
	output logic [sbb_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);
	import sbb_pkg::*;

	// size limits after saturation; registers are 8 bits, radius 4 bits
	localparam int W_LIM = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
	localparam int H_LIM = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;
	localparam int R_LIM = (MAX_RADIUS < RAD_CAP) ? MAX_RADIUS : RAD_CAP;
	localparam int CW    = (W_LIM > 1) ? $clog2(W_LIM) : 1;
	localparam int RW    = (H_LIM > 1) ? $clog2(H_LIM) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW    = (R_LIM > 0) ? $clog2(2 * R_LIM + 1) : 1;
	localparam int WORD_W = NUM_CH * PIX_W;

	// edge replication: negative goes to 0, past the end goes to n-1
	function automatic logic [SIZE_W-1:0] clamp_coord(input logic [COORD_SW-1:0] v,
		input logic [SIZE_W-1:0] n);
		logic [SIZE_W-1:0] res;
		if (v[COORD_SW-1]) begin
			res = '0;
		end else if (v >= {1'b0, n}) begin
			res = n - 1'b1;
		end else begin
			res = v[SIZE_W-1:0];
		end
		return res;
	endfunction

	// configuration registers
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [RAD_W-1:0]  radius_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			radius_q <= RADIUS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				REG_BLUR_RADIUS:  radius_q <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_q);
			REG_IMAGE_HEIGHT: prdata = CFG_DW'(height_q);
			REG_BLUR_RADIUS:  prdata = CFG_DW'(radius_q);
			default:          prdata = '0;
		endcase
	end

	// effective sizes: zero reads as one, large values saturate
	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [RAD_W-1:0]  r_eff;
	logic [KW-1:0]     win_last;
	logic [DIV_W-1:0]  win_len;

	always_comb begin
		if (width_q == '0) begin
			w_eff = SIZE_W'(1);
		end else if (int'(width_q) > W_LIM) begin
			w_eff = SIZE_W'(W_LIM);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (int'(height_q) > H_LIM) begin
			h_eff = SIZE_W'(H_LIM);
		end else begin
			h_eff = height_q;
		end
		if (int'(radius_q) > R_LIM) begin
			r_eff = RAD_W'(R_LIM);
		end else begin
			r_eff = radius_q;
		end
		win_last = KW'({r_eff, 1'b0});
		win_len  = {r_eff, 1'b1};
	end

	// control state
	sbb_state_t state_q, state_d;
	logic [KW-1:0] kx_q;
	logic [KW-1:0] ky_q;
	logic          rd_vld_s1;
	logic          out_valid_q;

	// query payload
	logic [6:0]    x_q;
	logic [6:0]    y_q;
	sum_vec_t      row_sum_q;
	sum_vec_t      col_sum_q;
	pix_t          res_pix_q;
	logic          res_err_q;
	pix_t          out_pix_q;
	logic          out_err_q;

	logic          in_acc;
	logic          in_inside;
	logic          rd_en;
	logic          div_start;
	logic          div_sel_col;

	assign in_acc    = in_valid && in_ready;
	assign in_inside = ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);

	// store ports
	logic [AW-1:0]     wr_addr;
	logic              wr_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	pix_t              rd_pix;
	logic [COORD_SW-1:0] cx_raw;
	logic [COORD_SW-1:0] cy_raw;
	logic [CW-1:0]       cx;
	logic [RW-1:0]       cy;

	assign wr_en   = in_acc && (kind == KIND_LOAD) && in_inside;
	assign wr_addr = AW'(int'(row) * MAX_WIDTH + int'(col));

	// window sample address, replicated at the edges
	assign cx_raw  = COORD_SW'(x_q) + COORD_SW'(kx_q) - COORD_SW'(r_eff);
	assign cy_raw  = COORD_SW'(y_q) + COORD_SW'(ky_q) - COORD_SW'(r_eff);
	assign cx      = CW'(clamp_coord(cx_raw, w_eff));
	assign cy      = RW'(clamp_coord(cy_raw, h_eff));
	assign rd_addr = AW'(int'(cy) * MAX_WIDTH + int'(cx));
	assign rd_pix  = pix_t'(rd_data);

	sbb_pixel_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (WORD_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({in_red, in_green, in_blue}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// divider shared by the row means and the final column mean
	div_req_t div_req;
	div_sts_t div_sts;
	sum_vec_t div_dividend;
	pix_t     div_quo;
	sum_vec_t row_sum_nxt;
	sum_vec_t col_sum_nxt;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			row_sum_nxt[c] = row_sum_q[c] + SUM_W'(rd_pix[c]);
			col_sum_nxt[c] = col_sum_q[c] + SUM_W'(div_quo[c]);
		end
		// the last sample or last row mean is forwarded straight into the divider
		div_dividend    = div_sel_col ? col_sum_nxt : row_sum_nxt;
		div_req.start   = div_start;
		div_req.divisor = win_len;
	end

	sbb_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	// sequencer: read a window row, divide it, fold into the column sum
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		rd_en       = 1'b0;
		div_start   = 1'b0;
		div_sel_col = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && kind == KIND_QUERY) begin
					state_d = in_inside ? ST_READ : ST_DONE;
				end
			end
			ST_READ: begin
				rd_en = 1'b1;
				if (kx_q == win_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last sample of the row is in rd_data now
				div_start = 1'b1;
				state_d   = ST_ROWDIV;
			end
			ST_ROWDIV: begin
				if (div_sts.done) begin
					if (ky_q == win_last) begin
						div_start   = 1'b1;
						div_sel_col = 1'b1;
						state_d     = ST_COLDIV;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_COLDIV: begin
				if (div_sts.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kx_q        <= '0;
			ky_q        <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (in_acc) begin
				kx_q <= '0;
				ky_q <= '0;
			end else if (state_q == ST_READ && kx_q != win_last) begin
				kx_q <= kx_q + 1'b1;
			end else if (state_q == ST_ROWDIV && div_sts.done) begin
				kx_q <= '0;
				if (ky_q != win_last) begin
					ky_q <= ky_q + 1'b1;
				end
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_QUERY) begin
			x_q       <= col;
			y_q       <= row;
			row_sum_q <= '0;
			col_sum_q <= '0;
			res_pix_q <= '0;
			res_err_q <= !in_inside;
		end else begin
			if (rd_vld_s1) begin
				row_sum_q <= row_sum_nxt;
			end
			if (state_q == ST_ROWDIV && div_sts.done) begin
				col_sum_q <= col_sum_nxt;
				row_sum_q <= '0;
			end
			if (state_q == ST_COLDIV && div_sts.done) begin
				res_pix_q <= div_quo;
				res_err_q <= 1'b0;
			end
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_pix_q <= res_pix_q;
			out_err_q <= res_err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = out_pix_q[2];
	assign out_green   = out_pix_q[1];
	assign out_blue    = out_pix_q[0];
	assign coord_error = out_err_q;

	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> rd_vld_s1)
		else $error("row drained without a pending store read");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_ROWDIV || state_q == ST_COLDIV))
		else $error("divide finished outside a divide state");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (kx_q <= win_last && ky_q <= win_last))
		else $error("window counter past the window");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished result not moved to output register");

endmodule
